// ===== src/top_rate_unchoke_selector_assert.svh =====
// Assertion macros used by the rate unchoke selector top level
`ifndef TOP_RATE_UNCHOKE_SELECTOR_ASSERT_SVH
`define TOP_RATE_UNCHOKE_SELECTOR_ASSERT_SVH

// same-cycle implication, gated by reset
`define TRUS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, gated by reset
`define TRUS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/trus_pkg.sv =====
// Types and constants of the rate unchoke selector
package trus_pkg;

  localparam int ID_W     = 16;
  localparam int RATE_W   = 32;
  localparam int CFG_IDX_W = 1;

  typedef logic [ID_W-1:0]   peer_id_t;
  typedef logic [RATE_W-1:0] rate_t;

  localparam logic [CFG_IDX_W-1:0] REG_UP_LIMIT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_LIMIT = 1'd1;

  localparam rate_t UP_LIMIT_RST   = 32'd51200;
  localparam rate_t DOWN_LIMIT_RST = 32'd103;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // broadcast to every cell
  typedef struct packed {
    logic     mark_seen;
    logic     commit;
    peer_id_t probe_id;
    peer_id_t wr_id;
    rate_t    wr_rate;
  } cell_ctl_t;

  // state and match flags of one cell
  typedef struct packed {
    logic     cand_v;
    peer_id_t cand_id;
    rate_t    cand_rate;
    logic     held_v;
    peer_id_t held_id;
    logic     seen;
    logic     held_hit;
    logic     cand_hit;
  } cell_stat_t;

endpackage

// ===== src/trus_cell.sv =====
// One slot: candidate entry, held entry, seen flag and a stage of the min-rate chain
module trus_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  trus_pkg::cell_ctl_t   ctl,
  input  logic                  load,
  input  trus_pkg::rate_t       min_in,
  output trus_pkg::rate_t       min_out,
  output trus_pkg::cell_stat_t  stat
);
  import trus_pkg::*;

  logic     cand_v_r, cand_v_nxt;
  peer_id_t cand_id_r, cand_id_nxt;
  rate_t    cand_rate_r, cand_rate_nxt;
  logic     held_v_r, held_v_nxt;
  peer_id_t held_id_r, held_id_nxt;
  logic     seen_r, seen_nxt;
  rate_t    min_r, min_nxt;
  logic     held_hit, cand_hit;

  assign held_hit = held_v_r && (held_id_r == ctl.probe_id);
  assign cand_hit = cand_v_r && (cand_id_r == ctl.probe_id);

  always_comb begin
    cand_v_nxt    = cand_v_r;
    cand_id_nxt   = cand_id_r;
    cand_rate_nxt = cand_rate_r;
    held_v_nxt    = held_v_r;
    held_id_nxt   = held_id_r;
    seen_nxt      = seen_r;
    if (ctl.commit) begin
      held_v_nxt    = cand_v_r;
      held_id_nxt   = cand_id_r;
      cand_v_nxt    = 1'b0;
      cand_id_nxt   = '0;
      cand_rate_nxt = '0;
      seen_nxt      = 1'b0;
    end else begin
      if (ctl.mark_seen && held_hit) begin
        seen_nxt = 1'b1;
      end
      if (load) begin
        cand_v_nxt    = 1'b1;
        cand_id_nxt   = ctl.wr_id;
        cand_rate_nxt = ctl.wr_rate;
      end
    end
  end

  // running minimum handed on to the next cell every cycle
  assign min_nxt = (cand_rate_r < min_in) ? cand_rate_r : min_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_v_r <= 1'b0;
      held_v_r <= 1'b0;
      seen_r   <= 1'b0;
    end else begin
      cand_v_r <= cand_v_nxt;
      held_v_r <= held_v_nxt;
      seen_r   <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_id_r   <= cand_id_nxt;
    cand_rate_r <= cand_rate_nxt;
    held_id_r   <= held_id_nxt;
    min_r       <= min_nxt;
  end

  assign min_out = min_r;

  always_comb begin
    stat.cand_v    = cand_v_r;
    stat.cand_id   = cand_id_r;
    stat.cand_rate = cand_rate_r;
    stat.held_v    = held_v_r;
    stat.held_id   = held_id_r;
    stat.seen      = seen_r;
    stat.held_hit  = held_hit;
    stat.cand_hit  = cand_hit;
  end

endmodule

// ===== src/top_rate_unchoke_selector.sv =====
// Top level: rate unchoke selector, a row of slot cells under a small sequencer
// Item without close: accepted in idle, then evaluated. Replacement in a full set adds
// a scan state while the min-rate chain through the cells settles.
// Close item: an emit pass over the candidate and held positions after evaluation (and
// any scan), held by any output stall; results are registered.
// Reset: synchronous, active low; clears both sets, seen flags, limits to defaults.
module top_rate_unchoke_selector #(
  parameter int SLOTS = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  trus_pkg::peer_id_t                in_peer_id,
  input  trus_pkg::rate_t                   in_down_rate,
  input  trus_pkg::rate_t                   in_up_rate,
  input  logic                              in_eligible,
  input  logic                              in_peer_valid,
  input  logic                              in_last_peer,
  output logic                              out_valid,
  input  logic                              out_ready,
  output trus_pkg::peer_id_t                out_target_id,
  output logic                              out_unchoke,
  output logic                              out_final_change,
  input  logic                              cfg_we,
  input  logic [trus_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  trus_pkg::rate_t                   cfg_wdata
);
  import trus_pkg::*;
  `include "top_rate_unchoke_selector_assert.svh"

  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int NPOS  = 2 * SLOTS;
  localparam int POS_W = $clog2(NPOS + 1);
  localparam int IDX_W = $clog2(NPOS);
  localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(SLOTS);
  localparam logic [POS_W-1:0] POS_END  = POS_W'(NPOS);

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;

  rate_t up_limit_r, down_limit_r;

  peer_id_t id_r;
  rate_t    down_r, up_r;
  logic     elig_r, pvalid_r, last_r;

  logic     out_valid_r;
  peer_id_t out_id_r;
  logic     out_unch_r, out_final_r;

  cell_ctl_t  ctl;
  cell_stat_t stat [SLOTS];
  rate_t      chain [SLOTS+1];
  logic [SLOTS-1:0] load_sel;
  logic [SLOTS-1:0] cand_v_vec, held_v_vec, seen_vec;

  logic any_held_hit, any_cand_hit, forced, compete, full, replace;
  logic [SLOTS-1:0] first_empty, first_min;
  logic [NPOS-1:0]  flags;
  peer_id_t         ids_all [NPOS];
  logic [IDX_W-1:0] pos_idx;
  logic             later;
  logic             fire_in, do_load, do_replace, out_load, commit;

  assign fire_in = in_valid && in_ready;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_limit_r   <= UP_LIMIT_RST;
      down_limit_r <= DOWN_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_UP_LIMIT:   up_limit_r   <= cfg_wdata;
        REG_DOWN_LIMIT: down_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // captured item
  always_ff @(posedge clk) begin
    if (fire_in) begin
      id_r     <= in_peer_id;
      down_r   <= in_down_rate;
      up_r     <= in_up_rate;
      elig_r   <= in_eligible;
      pvalid_r <= in_peer_valid;
      last_r   <= in_last_peer;
    end
  end

  // cell row
  assign chain[0] = '1;
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    trus_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .load    (load_sel[g]),
      .min_in  (chain[g]),
      .min_out (chain[g+1]),
      .stat    (stat[g])
    );
    assign cand_v_vec[g] = stat[g].cand_v;
    assign held_v_vec[g] = stat[g].held_v;
    assign seen_vec[g]   = stat[g].seen;
  end

  // per-item decision
  always_comb begin
    any_held_hit = 1'b0;
    any_cand_hit = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      any_held_hit = any_held_hit | stat[i].held_hit;
      any_cand_hit = any_cand_hit | stat[i].cand_hit;
    end
  end

  assign forced  = any_held_hit && (up_r > up_limit_r) && (down_r < down_limit_r);
  assign compete = pvalid_r && elig_r && !forced && !any_cand_hit;
  assign full    = &cand_v_vec;
  assign replace = down_r >= chain[SLOTS];

  always_comb begin
    logic found_e, found_m;
    found_e = 1'b0;
    found_m = 1'b0;
    first_empty = '0;
    first_min   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!found_e && !stat[i].cand_v) begin
        first_empty[i] = 1'b1;
        found_e = 1'b1;
      end
      if (!found_m && (stat[i].cand_rate == chain[SLOTS])) begin
        first_min[i] = 1'b1;
        found_m = 1'b1;
      end
    end
  end

  // change flags for the close: unchokes in slot order, then chokes in held order
  always_comb begin
    logic hit_h, hit_c;
    for (int i = 0; i < SLOTS; i++) begin
      hit_h = 1'b0;
      hit_c = 1'b0;
      for (int j = 0; j < SLOTS; j++) begin
        hit_h = hit_h | (stat[j].held_v && (stat[j].held_id == stat[i].cand_id));
        hit_c = hit_c | (stat[j].cand_v && (stat[j].cand_id == stat[i].held_id));
      end
      flags[i]         = stat[i].cand_v && !hit_h;
      flags[SLOTS + i] = stat[i].held_v && stat[i].seen && !hit_c;
      ids_all[i]         = stat[i].cand_id;
      ids_all[SLOTS + i] = stat[i].held_id;
    end
  end

  assign pos_idx = pos_r[IDX_W-1:0];

  always_comb begin
    later = 1'b0;
    for (int k = 0; k < NPOS; k++) begin
      later = later | (flags[k] && (POS_W'(k) > pos_r));
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (fire_in) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (compete && full) state_nxt = ST_SCAN;
        else if (last_r)     state_nxt = ST_EMIT;
        else                 state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (cnt_r == SCAN_END) state_nxt = last_r ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (pos_r == POS_END) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready   = 1'b0;
    do_load    = 1'b0;
    do_replace = 1'b0;
    out_load   = 1'b0;
    commit     = 1'b0;
    cnt_nxt    = '0;
    pos_nxt    = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_EVAL: begin
        do_load = compete && !full;
      end
      ST_SCAN: begin
        if (cnt_r == SCAN_END) begin
          do_replace = replace;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_EMIT: begin
        pos_nxt = pos_r;
        if (pos_r == POS_END) begin
          commit = 1'b1;
        end else if (!flags[pos_idx]) begin
          pos_nxt = pos_r + 1'b1;
        end else if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          pos_nxt  = pos_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    ctl.mark_seen = (state_r == ST_EVAL) && pvalid_r;
    ctl.commit    = commit;
    ctl.probe_id  = id_r;
    ctl.wr_id     = id_r;
    ctl.wr_rate   = down_r;
    load_sel = do_load ? first_empty : (do_replace ? first_min : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pos_r   <= pos_nxt;
      if (out_load)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_id_r    <= ids_all[pos_idx];
      out_unch_r  <= (pos_r < POS_W'(SLOTS));
      out_final_r <= !later;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_target_id    = out_id_r;
  assign out_unchoke      = out_unch_r;
  assign out_final_change = out_final_r;

  `TRUS_ASSERT_IMPL(a_cand_prefix, 1'b1, ((cand_v_vec >> 1) & ~cand_v_vec) == '0, "cand gap")
  `TRUS_ASSERT_IMPL(a_held_prefix, 1'b1, ((held_v_vec >> 1) & ~held_v_vec) == '0, "held gap")
  `TRUS_ASSERT_NEXT(a_commit_clear, commit, (cand_v_vec == '0) && (seen_vec == '0),
                    "commit left state")
  `TRUS_ASSERT_NEXT(a_accept_eval, fire_in, state_r == ST_EVAL, "item not evaluated")
  `TRUS_ASSERT_IMPL(a_load_onehot, 1'b1, $onehot0(load_sel), "multiple slot writes")

endmodule

// ===== bench/tb_top_rate_unchoke_selector.sv =====
// Self-checking bench for the rate unchoke selector: table-driven rounds, then random rounds
`timescale 1ns / 100ps

module tb_top_rate_unchoke_selector;
  import trus_pkg::*;

  localparam int SLOTS        = 4;
  localparam int DIR_N        = 22;
  localparam int SEGMENTS     = 6;
  localparam int SEG_ITEMS    = 38;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    peer_id_t id;
    rate_t    down;
    rate_t    up;
    logic     elig;
    logic     pv;
    logic     last;
  } peer_offer_t;

  typedef struct {
    peer_id_t id;
    logic     unchoke;
    logic     fin;
  } choke_change_t;

  typedef struct {
    peer_id_t id;
    rate_t    down;
    rate_t    up;
    logic     elig;
    logic     pv;
    logic     last;
    logic     has_exp;
    peer_id_t exp_id;
    logic     exp_unchoke;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  peer_id_t           in_peer_id = '0;
  rate_t              in_down_rate = '0;
  rate_t              in_up_rate = '0;
  logic               in_eligible = 1'b0;
  logic               in_peer_valid = 1'b0;
  logic               in_last_peer = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  peer_id_t           out_target_id;
  logic               out_unchoke;
  logic               out_final_change;
  logic               cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  rate_t              cfg_wdata = '0;

  top_rate_unchoke_selector #(.SLOTS(SLOTS)) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_peer_id      (in_peer_id),
    .in_down_rate    (in_down_rate),
    .in_up_rate      (in_up_rate),
    .in_eligible     (in_eligible),
    .in_peer_valid   (in_peer_valid),
    .in_last_peer    (in_last_peer),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_target_id   (out_target_id),
    .out_unchoke     (out_unchoke),
    .out_final_change(out_final_change),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  rate_t            up_lim = UP_LIMIT_RST;
  rate_t            down_lim = DOWN_LIMIT_RST;
  peer_id_t         cand_ids [SLOTS];
  rate_t            cand_rates [SLOTS];
  int               cand_n = 0;
  peer_id_t         held_ids [SLOTS];
  int               held_n = 0;
  logic [SLOTS-1:0] held_seen = '0;

  choke_change_t    close_changes [$];
  choke_change_t    pending_changes [$];

  int     in_idle_pct = 0;
  int     out_idle_pct = 0;
  bit     hold_request = 0;
  bit     hold_done = 0;
  int     hold_cnt = 0;
  int     err_cnt = 0;
  int     compared = 0;
  int     offered = 0;
  int     rounds = 0;
  int     settings = 1;
  int     cycles = 0;
  rate_t  prev_rate = '0;

  peer_id_t id_pool [10] = '{16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'h0004,
                             16'h0005, 16'h0006, 16'h0007, 16'h8000, 16'hFFFF};

  dir_row_t directed_rows [DIR_N] = '{
    '{16'hFFFF, 32'hFFFF_FFFF, 32'd0,          1, 1, 1, 1, 16'hFFFF, 1},
    '{16'h0000, 32'd0,         32'hFFFF_FFFF,  1, 1, 0, 0, 16'h0000, 0},
    '{16'hFFFF, 32'd0,         32'hFFFF_FFFF,  1, 1, 0, 0, 16'h0000, 0},
    '{16'h0000, 32'd0,         32'd0,          0, 0, 1, 0, 16'h0000, 0},
    '{16'd10,   32'd500,       32'd0,          1, 1, 0, 0, 16'h0000, 0},
    '{16'd11,   32'd300,       32'd0,          1, 1, 0, 0, 16'h0000, 0},
    '{16'd12,   32'd300,       32'd0,          1, 1, 0, 0, 16'h0000, 0},
    '{16'd13,   32'd800,       32'd0,          1, 1, 0, 0, 16'h0000, 0},
    '{16'd10,   32'd9999,      32'd0,          1, 1, 0, 0, 16'h0000, 0},
    '{16'd14,   32'd5000,      32'd0,          0, 1, 0, 0, 16'h0000, 0},
    '{16'd15,   32'd300,       32'd0,          1, 1, 0, 0, 16'h0000, 0},
    '{16'd16,   32'd100,       32'd0,          1, 1, 0, 0, 16'h0000, 0},
    '{16'd17,   32'hFFFF_FFFF, 32'd0,          1, 1, 1, 0, 16'h0000, 0},
    '{16'd10,   32'd50,        32'd0,          1, 1, 0, 0, 16'h0000, 0},
    '{16'd13,   32'd0,         32'd0,          0, 1, 0, 0, 16'h0000, 0},
    '{16'h0000, 32'd0,         32'd0,          0, 0, 1, 0, 16'h0000, 0},
    '{16'h0000, 32'd0,         32'd0,          0, 0, 1, 0, 16'h0000, 0},
    '{16'd20,   32'd0,         32'd0,          1, 1, 1, 1, 16'd20,   1},
    '{16'd20,   32'd0,         32'd51200,      1, 1, 1, 0, 16'h0000, 0},
    '{16'd20,   32'd103,       32'd51201,      1, 1, 1, 0, 16'h0000, 0},
    '{16'd20,   32'd102,       32'd51201,      1, 1, 1, 1, 16'd20,   0},
    '{16'h0000, 32'd0,         32'd0,          0, 0, 1, 0, 16'h0000, 0}
  };

  function automatic int held_slot(peer_id_t id);
    for (int i = 0; i < held_n; i++)
      if (held_ids[i] == id) return i;
    return -1;
  endfunction

  function automatic bit is_candidate(peer_id_t id);
    for (int i = 0; i < cand_n; i++)
      if (cand_ids[i] == id) return 1;
    return 0;
  endfunction

  task automatic predict_offer(input peer_offer_t p);
    int h;
    bit forced;
    int j;
    close_changes.delete();
    if (p.pv) begin
      h = held_slot(p.id);
      forced = 0;
      if (h >= 0) begin
        held_seen[h] = 1'b1;
        forced = (p.up > up_lim) && (p.down < down_lim);
      end
      if (p.elig && !forced && !is_candidate(p.id)) begin
        if (cand_n < SLOTS) begin
          cand_ids[cand_n] = p.id;
          cand_rates[cand_n] = p.down;
          cand_n++;
        end else begin
          j = 0;
          for (int i = 1; i < SLOTS; i++)
            if (cand_rates[i] < cand_rates[j]) j = i;
          if (p.down >= cand_rates[j]) begin
            cand_ids[j] = p.id;
            cand_rates[j] = p.down;
          end
        end
      end
    end
    if (p.last) begin
      for (int i = 0; i < cand_n; i++)
        if (held_slot(cand_ids[i]) < 0) close_changes.push_back('{cand_ids[i], 1'b1, 1'b0});
      for (int i = 0; i < held_n; i++)
        if (held_seen[i] && !is_candidate(held_ids[i]))
          close_changes.push_back('{held_ids[i], 1'b0, 1'b0});
      if (close_changes.size() > 0) close_changes[close_changes.size()-1].fin = 1'b1;
      for (int i = 0; i < SLOTS; i++) begin
        held_ids[i] = (i < cand_n) ? cand_ids[i] : '0;
        cand_ids[i] = '0;
        cand_rates[i] = '0;
      end
      held_n = cand_n;
      cand_n = 0;
      held_seen = '0;
      rounds++;
    end
  endtask

  task automatic offer_peer(input peer_offer_t p, input bit has_exp, input choke_change_t exp_c);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_peer_id = p.id;
    in_down_rate = p.down;
    in_up_rate = p.up;
    in_eligible = p.elig;
    in_peer_valid = p.pv;
    in_last_peer = p.last;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_offer(p);
    if (has_exp) pending_changes.push_back(exp_c);
    else foreach (close_changes[i]) pending_changes.push_back(close_changes[i]);
    if (p.pv) offered++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input rate_t val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_UP_LIMIT) up_lim = val;
    else if (idx == REG_DOWN_LIMIT) down_lim = val;
  endtask

  task automatic settle_block();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_changes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic rate_t rand_rate();
    rate_t r;
    case ($urandom_range(7))
      0: r = '0;
      1: r = $urandom_range(300);
      2: r = up_lim + $urandom_range(4) - 2;
      3: r = down_lim + $urandom_range(4) - 2;
      4: r = prev_rate;
      5: r = 32'hFFFF_FFFF;
      default: r = $urandom;
    endcase
    prev_rate = r;
    return r;
  endfunction

  function automatic peer_offer_t rand_peer();
    peer_offer_t p;
    p.id = ($urandom_range(99) < 70) ? id_pool[$urandom_range(9)] : peer_id_t'($urandom);
    p.down = rand_rate();
    p.up = rand_rate();
    p.elig = $urandom_range(99) < 85;
    p.pv = 1'b1;
    p.last = 1'b0;
    return p;
  endfunction

  task automatic random_rounds(input int n_items);
    int count;
    int len;
    bit empty_close;
    peer_offer_t p;
    choke_change_t none;
    count = 0;
    none = '{'0, 1'b0, 1'b0};
    while (count < n_items) begin
      if ($urandom_range(99) < 6) begin
        // stray item carrying no peer and no close
        p = rand_peer();
        p.pv = 1'b0;
        offer_peer(p, 0, none);
      end else begin
        len = $urandom_range(1, 9);
        empty_close = $urandom_range(99) < 15;
        for (int k = 0; k < len; k++) begin
          p = rand_peer();
          p.last = (k == len - 1) && !empty_close;
          offer_peer(p, 0, none);
          count++;
        end
        if (empty_close) begin
          p = rand_peer();
          p.pv = 1'b0;
          p.last = 1'b1;
          offer_peer(p, 0, none);
        end
      end
    end
  endtask

  // receiver: random back-pressure plus one long hold-off
  always @(negedge clk) begin
    if (hold_request && !hold_done) begin
      hold_cnt = HOLD_CYCLES;
      hold_done = 1;
    end
    if (hold_cnt > 0) begin
      out_ready = 1'b0;
      hold_cnt--;
    end else begin
      out_ready = $urandom_range(99) >= out_idle_pct;
    end
  end

  always @(posedge clk) begin : result_check
    choke_change_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_changes.size() == 0) begin
        $error("unexpected result: target_id %h unchoke %b", out_target_id, out_unchoke);
        err_cnt++;
      end else begin
        want = pending_changes.pop_front();
        compared++;
        if (out_target_id !== want.id) begin
          $error("target_id: expected %h, got %h", want.id, out_target_id);
          err_cnt++;
        end
        if (out_unchoke !== want.unchoke) begin
          $error("unchoke: expected %b, got %b", want.unchoke, out_unchoke);
          err_cnt++;
        end
        if (out_final_change !== want.fin) begin
          $error("final_change: expected %b, got %b", want.fin, out_final_change);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top_rate_unchoke_selector NOT OK");
      $finish;
    end
  end

  initial begin
    peer_offer_t p;
    choke_change_t c;
    for (int i = 0; i < SLOTS; i++) begin
      cand_ids[i] = '0;
      cand_rates[i] = '0;
      held_ids[i] = '0;
    end
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    in_idle_pct = 8;
    out_idle_pct = 70;
    foreach (directed_rows[r]) begin
      p = '{directed_rows[r].id, directed_rows[r].down, directed_rows[r].up,
            directed_rows[r].elig, directed_rows[r].pv, directed_rows[r].last};
      c = '{directed_rows[r].exp_id, directed_rows[r].exp_unchoke, 1'b1};
      offer_peer(p, directed_rows[r].has_exp, c);
    end

    for (int s = 0; s < SEGMENTS; s++) begin
      settle_block();
      case (s)
        0: begin write_reg(REG_UP_LIMIT, UP_LIMIT_RST); write_reg(REG_DOWN_LIMIT, DOWN_LIMIT_RST); end
        1: begin write_reg(REG_UP_LIMIT, '0); write_reg(REG_DOWN_LIMIT, '0); end
        2: begin write_reg(REG_UP_LIMIT, '0); write_reg(REG_DOWN_LIMIT, 32'hFFFF_FFFF); end
        3: begin write_reg(REG_UP_LIMIT, 32'hFFFF_FFFF); write_reg(REG_DOWN_LIMIT, 32'hFFFF_FFFF); end
        4: begin write_reg(REG_UP_LIMIT, $urandom_range(100000)); write_reg(REG_DOWN_LIMIT, $urandom); end
        default: begin write_reg(REG_UP_LIMIT, 32'hFFFF_FFFF); write_reg(REG_DOWN_LIMIT, '0); end
      endcase
      settings++;
      if (s < 2) begin
        in_idle_pct = 8;
        out_idle_pct = 70;
      end else if (s < 4) begin
        in_idle_pct = 70;
        out_idle_pct = 8;
      end else begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      if (s == 4) hold_request = 1;
      random_rounds(SEG_ITEMS);
    end

    settle_block();
    $display("Offered %0d peers over %0d rounds under %0d limit settings;", offered, rounds,
             settings);
    $display("%0d choke changes compared, %0d mismatches.", compared, err_cnt);
    if (err_cnt == 0)
      $display("tb_top_rate_unchoke_selector OK");
    else
      $display("tb_top_rate_unchoke_selector NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/trus_pkg.sv
src/trus_cell.sv
src/top_rate_unchoke_selector.sv
bench/tb_top_rate_unchoke_selector.sv
